@@ hdl/rtpjb_pkg.sv @@
// Shared types and constants of the RTP reorder jitter buffer.
package rtpjb_pkg;

  // Slot index is the low bits of the sequence number; depth is a power of two.
  localparam int unsigned RING_DEPTH = 32;
  localparam int unsigned SLOT_W     = $clog2(RING_DEPTH);
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CNT_W      = 6;

  localparam logic [15:0] MIN_PKT_LEN     = 16'd12;
  localparam logic [15:0] MAX_LEN_RST     = 16'd2048;
  localparam logic [15:0] FRAME_BYTES_RST = 16'd1408;
  localparam logic [CNT_W-1:0] CNT_MAX    = '1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET_LEN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES    = 8'd1;

  typedef enum logic [1:0] {
    ACT_STORE  = 2'd0,
    ACT_TAKE   = 2'd1,
    ACT_RESEND = 2'd2,
    ACT_FLUSH  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_STORED  = 3'd1,
    ST_BAD_LEN = 3'd2,
    ST_IGNORED = 3'd3,
    ST_FRAME   = 3'd4,
    ST_SILENCE = 3'd5,
    ST_RESEND  = 3'd6
  } status_e;

  // One ring slot as held in the slot memory.
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [7:0]       flags;
    logic [7:0]       typ;
    logic [31:0]      timestamp;
    logic [31:0]      ssrc;
    logic [15:0]      len;
  } slot_t;

  typedef struct packed {
    status_e          status;
    logic [SEQ_W-1:0] seq;
    logic [SLOT_W-1:0] slot;
    logic [15:0]      len;
    logic [7:0]       flags;
    logic [7:0]       typ;
    logic [31:0]      timestamp;
    logic [31:0]      ssrc;
    logic [CNT_W-1:0] resend_count;
  } res_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } scan_t;

endpackage

@@ hdl/rtpjb_in_if.sv @@
// Input item channel of the jitter buffer.
interface rtpjb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] seq_in;
  logic        use_seq;
  logic        skip_wait;
  logic        flush_empty;
  logic [15:0] packet_len;
  logic [7:0]  pkt_flags;
  logic [7:0]  pkt_type;
  logic [31:0] pkt_timestamp;
  logic [31:0] pkt_ssrc;
  logic [15:0] payload_len;

  modport source (
    output valid, action, seq_in, use_seq, skip_wait, flush_empty, packet_len,
           pkt_flags, pkt_type, pkt_timestamp, pkt_ssrc, payload_len,
    input  ready
  );
  modport sink (
    input  valid, action, seq_in, use_seq, skip_wait, flush_empty, packet_len,
           pkt_flags, pkt_type, pkt_timestamp, pkt_ssrc, payload_len,
    output ready
  );
endinterface

@@ hdl/rtpjb_out_if.sv @@
// Result channel of the jitter buffer.
interface rtpjb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] out_seq;
  logic [4:0]  out_slot;
  logic [15:0] out_len;
  logic [7:0]  out_flags;
  logic [7:0]  out_type;
  logic [31:0] out_timestamp;
  logic [31:0] out_ssrc;
  logic [5:0]  resend_count;

  modport source (
    output valid, status, out_seq, out_slot, out_len, out_flags, out_type,
           out_timestamp, out_ssrc, resend_count,
    input  ready
  );
  modport sink (
    input  valid, status, out_seq, out_slot, out_len, out_flags, out_type,
           out_timestamp, out_ssrc, resend_count,
    output ready
  );
endinterface

@@ hdl/rtpjb_cfg_if.sv @@
// Configuration write channel of the jitter buffer.
interface rtpjb_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/rtpjb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module rtpjb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/rtpjb_gap_scan.sv @@
// Valid-bit scan: registered rotation to the oldest slot, then first-set search.
module rtpjb_gap_scan (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic [rtpjb_pkg::RING_DEPTH-1:0]    valid_i,
  input  logic [rtpjb_pkg::SLOT_W-1:0]        base_i,
  output rtpjb_pkg::scan_t                    scan_o
);

  logic [2*rtpjb_pkg::RING_DEPTH-1:0] dbl;
  logic [rtpjb_pkg::RING_DEPTH-1:0]   rot_d;
  logic [rtpjb_pkg::RING_DEPTH-1:0]   rot_q;

  // bit i of rot is the slot i steps past the oldest one
  assign dbl   = {valid_i, valid_i} >> base_i;
  assign rot_d = dbl[rtpjb_pkg::RING_DEPTH-1:0];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rot_q <= rot_d;
    end
  end

  always_comb begin
    scan_o = '0;
    for (int i = rtpjb_pkg::RING_DEPTH - 1; i >= 0; i--) begin
      if (rot_q[i]) begin
        scan_o.found = 1'b1;
        scan_o.idx   = rtpjb_pkg::SLOT_W'(i);
      end
    end
  end

endmodule

@@ hdl/rtpjb_out_reg.sv @@
// Output register between the ring control and the result channel.
module rtpjb_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rtpjb_pkg::res_t     res_i,
  output logic                free_o,
  rtpjb_out_if.source         res_o
);

  logic            valid_q;
  rtpjb_pkg::res_t res_q;

  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.status        = res_q.status;
  assign res_o.out_seq       = res_q.seq;
  assign res_o.out_slot      = res_q.slot;
  assign res_o.out_len       = res_q.len;
  assign res_o.out_flags     = res_q.flags;
  assign res_o.out_type      = res_q.typ;
  assign res_o.out_timestamp = res_q.timestamp;
  assign res_o.out_ssrc      = res_q.ssrc;
  assign res_o.resend_count  = res_q.resend_count;

endmodule

@@ hdl/rtp_reorder_jitter_buffer_core.sv @@
// Sequence-indexed reorder ring for RTP packets: store, take, resend check, flush.
// Each beat passes S_IDLE then S_EXEC: the accept reads the slot memory at the
// slot of the sequence number (and snapshots the valid bits rotated to the oldest
// slot), then S_EXEC sees the registered read data, decides and writes back. So the
// block takes a new beat only once the last one has committed; a stalled result
// channel holds S_EXEC until the output register frees. The header store is a
// 32-entry memory with no reset; slot valid bits live in flip-flops cleared by reset,
// so no clearing pass runs after reset. Sequence comparisons are signed 16-bit
// differences. Configuration writes are taken in any cycle, ready is always high.
module rtp_reorder_jitter_buffer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtpjb_in_if.sink    item_i,
  rtpjb_out_if.source result_o,
  rtpjb_cfg_if.sink   cfg_i
);

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  typedef struct packed {
    rtpjb_pkg::action_e action;
    logic [15:0]        seq_in;
    logic               use_seq;
    logic               skip_wait;
    logic               flush_empty;
    logic [15:0]        packet_len;
    logic [7:0]         pkt_flags;
    logic [7:0]         pkt_type;
    logic [31:0]        pkt_timestamp;
    logic [31:0]        pkt_ssrc;
    logic [15:0]        payload_len;
  } in_t;

  state_e                           state_q, state_d;
  in_t                              in_q, in_d;
  logic [rtpjb_pkg::SLOT_W-1:0]     slot_q, slot_d;
  logic [rtpjb_pkg::RING_DEPTH-1:0] valid_q, valid_d;
  logic [15:0]                      oldest_q, oldest_d;
  logic [15:0]                      newest_q, newest_d;
  logic                             empty_q, empty_d;
  logic [15:0]                      max_len_q, frame_q;

  logic                         in_acc;
  logic                         commit;
  logic                         out_free;
  logic [15:0]                  acc_seq;
  logic [rtpjb_pkg::SLOT_W-1:0] rd_slot;
  logic [rtpjb_pkg::SLOT_W-1:0] raddr;
  logic                         ram_we;
  rtpjb_pkg::slot_t             wr_slot;
  rtpjb_pkg::slot_t             rd_data;
  rtpjb_pkg::scan_t             scan;
  rtpjb_pkg::res_t              res_d;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= rtpjb_pkg::MAX_LEN_RST;
      frame_q   <= rtpjb_pkg::FRAME_BYTES_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rtpjb_pkg::REG_MAX_PACKET_LEN: max_len_q <= cfg_i.data;
        rtpjb_pkg::REG_FRAME_BYTES:    frame_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign item_i.ready = (state_q == S_IDLE);
  assign in_acc       = item_i.valid && item_i.ready;
  assign commit       = (state_q == S_EXEC) && out_free;

  assign acc_seq = item_i.use_seq ? item_i.seq_in : oldest_q;
  assign rd_slot = (rtpjb_pkg::action_e'(item_i.action) == rtpjb_pkg::ACT_STORE)
                 ? acc_seq[rtpjb_pkg::SLOT_W-1:0] : oldest_q[rtpjb_pkg::SLOT_W-1:0];
  // hold the read address so the read data stays put while the result stalls
  assign raddr   = in_acc ? rd_slot : slot_q;

  rtpjb_ram #(
    .WIDTH ($bits(rtpjb_pkg::slot_t)),
    .DEPTH (rtpjb_pkg::RING_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (wr_slot),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  rtpjb_gap_scan u_scan (
    .clk_i   (clk_i),
    .load_i  (in_acc),
    .valid_i (valid_q),
    .base_i  (oldest_q[rtpjb_pkg::SLOT_W-1:0]),
    .scan_o  (scan)
  );

  rtpjb_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (commit),
    .res_i  (res_d),
    .free_o (out_free),
    .res_o  (result_o)
  );

  assign wr_slot = '{seq:       in_q.use_seq ? in_q.seq_in : oldest_q,
                     flags:     in_q.pkt_flags,
                     typ:       in_q.pkt_type,
                     timestamp: in_q.pkt_timestamp,
                     ssrc:      in_q.pkt_ssrc,
                     len:       in_q.payload_len};

  always_comb begin
    logic [15:0] seq;
    logic [15:0] d_old;
    logic [15:0] d_ovr;
    logic [15:0] d_new;
    logic [15:0] o0;
    logic [15:0] n0;
    logic [15:0] fill;
    logic [15:0] span;
    logic [15:0] gap;
    logic        bad;
    logic        late;
    logic        overrun;
    logic        vs;
    logic        dup;

    state_d  = state_q;
    in_d     = in_q;
    slot_d   = slot_q;
    valid_d  = valid_q;
    oldest_d = oldest_q;
    newest_d = newest_q;
    empty_d  = empty_q;
    res_d    = rtpjb_pkg::res_t'('0);
    ram_we   = 1'b0;

    seq     = in_q.use_seq ? in_q.seq_in : oldest_q;
    bad     = (in_q.packet_len < rtpjb_pkg::MIN_PKT_LEN) || (in_q.packet_len > max_len_q);
    d_old   = seq - oldest_q;
    late    = !empty_q && d_old[15];
    d_ovr   = seq - oldest_q - 16'(rtpjb_pkg::RING_DEPTH);
    overrun = !d_ovr[15];
    vs      = valid_q[slot_q];
    dup     = !overrun && vs && (rd_data.seq == seq);
    o0      = overrun ? seq : oldest_q;
    n0      = overrun ? seq - 16'd1 : newest_q;
    if (empty_q) begin
      o0 = seq;
      n0 = seq;
    end
    d_new   = seq - n0;
    fill    = newest_q + 16'd1 - oldest_q;
    span    = newest_q - oldest_q;
    gap     = (scan.found && (16'(scan.idx) < span)) ? 16'(scan.idx) : span;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
          slot_d  = rd_slot;
          in_d    = '{action:        rtpjb_pkg::action_e'(item_i.action),
                      seq_in:        item_i.seq_in,
                      use_seq:       item_i.use_seq,
                      skip_wait:     item_i.skip_wait,
                      flush_empty:   item_i.flush_empty,
                      packet_len:    item_i.packet_len,
                      pkt_flags:     item_i.pkt_flags,
                      pkt_type:      item_i.pkt_type,
                      pkt_timestamp: item_i.pkt_timestamp,
                      pkt_ssrc:      item_i.pkt_ssrc,
                      payload_len:   item_i.payload_len};
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
          unique case (in_q.action)
            rtpjb_pkg::ACT_STORE: begin
              if (bad) begin
                res_d.status = rtpjb_pkg::ST_BAD_LEN;
              end else if (late || dup) begin
                res_d.status = rtpjb_pkg::ST_IGNORED;
              end else begin
                ram_we = 1'b1;
                // window overrun drops every slot before the write
                if (overrun) begin
                  valid_d = '0;
                end
                valid_d[slot_q] = 1'b1;
                empty_d  = 1'b0;
                oldest_d = o0;
                newest_d = (!d_new[15] && (d_new != 16'd0)) ? seq : n0;
                res_d.status = rtpjb_pkg::ST_STORED;
                res_d.seq    = seq;
                res_d.slot   = slot_q;
                res_d.len    = in_q.payload_len;
              end
            end
            rtpjb_pkg::ACT_TAKE: begin
              if (empty_q || fill[15] || (fill == 16'd0)) begin
                res_d.status = rtpjb_pkg::ST_NONE;
              end else if (!in_q.skip_wait && !vs &&
                           (fill < 16'(rtpjb_pkg::RING_DEPTH))) begin
                res_d.status = rtpjb_pkg::ST_NONE;
              end else begin
                oldest_d   = oldest_q + 16'd1;
                res_d.seq  = oldest_q;
                res_d.slot = slot_q;
                if (!vs) begin
                  res_d.status = rtpjb_pkg::ST_SILENCE;
                  res_d.len    = frame_q;
                end else begin
                  valid_d[slot_q]  = 1'b0;
                  res_d.status     = rtpjb_pkg::ST_FRAME;
                  res_d.len        = rd_data.len;
                  res_d.flags      = rd_data.flags;
                  res_d.typ        = rd_data.typ;
                  res_d.timestamp  = rd_data.timestamp;
                  res_d.ssrc       = rd_data.ssrc;
                end
              end
            end
            rtpjb_pkg::ACT_RESEND: begin
              // oldest strictly behind newest, nonzero gap to the first stored slot
              if (span[15] == 1'b0 && span != 16'd0 || span == 16'h8000) begin
                if (gap != 16'd0) begin
                  res_d.status       = rtpjb_pkg::ST_RESEND;
                  res_d.seq          = oldest_q;
                  res_d.resend_count = (gap > 16'(rtpjb_pkg::CNT_MAX))
                                     ? rtpjb_pkg::CNT_MAX : gap[rtpjb_pkg::CNT_W-1:0];
                end
              end
            end
            rtpjb_pkg::ACT_FLUSH: begin
              valid_d = '0;
              if (in_q.flush_empty) begin
                empty_d = 1'b1;
              end else begin
                oldest_d = in_q.seq_in;
                newest_d = in_q.seq_in - 16'd1;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      in_q     <= '0;
      slot_q   <= '0;
      valid_q  <= '0;
      oldest_q <= '0;
      newest_q <= '0;
      empty_q  <= 1'b1;
    end else begin
      state_q  <= state_d;
      in_q     <= in_d;
      slot_q   <= slot_d;
      valid_q  <= valid_d;
      oldest_q <= oldest_d;
      newest_q <= newest_d;
      empty_q  <= empty_d;
    end
  end

  a_empty_no_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (valid_q == '0))
    else $error("empty ring holds valid slots");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_EXEC))
    else $error("accepted beat not executed");

  a_frame_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && res_d.status == rtpjb_pkg::ST_FRAME) |-> valid_q[slot_q])
    else $error("frame taken from an invalid slot");

  a_store_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(slot_q)])
    else $error("stored slot not marked valid");

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the RTP reorder jitter buffer core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rtpjb_pkg::*;

  typedef struct {
    action_e     action;
    logic [15:0] seq_in;
    logic        use_seq;
    logic        skip_wait;
    logic        flush_empty;
    logic [15:0] packet_len;
    logic [7:0]  flags;
    logic [7:0]  ptype;
    logic [31:0] timestamp;
    logic [31:0] ssrc;
    logic [15:0] payload_len;
  } jb_item_t;

  // Mirrors the reorder ring and checks each result beat against it.
  class ring_scoreboard;
    bit          live[RING_DEPTH];
    slot_t       slots[RING_DEPTH];
    logic [15:0] oldest;
    logic [15:0] newest;
    bit          empty;
    logic [15:0] max_len;
    logic [15:0] silence_len;
    res_t        due_results[$];
    int          errors;
    int          n_items;
    int          n_checked;
    int          status_hits[8];

    function new();
      foreach (live[i]) begin
        live[i]  = 1'b0;
        slots[i] = '0;
      end
      oldest      = '0;
      newest      = '0;
      empty       = 1'b1;
      max_len     = MAX_LEN_RST;
      silence_len = FRAME_BYTES_RST;
    endfunction

    function int seq_delta(logic [15:0] a, logic [15:0] b);
      logic [15:0] d;
      d = a - b;
      return int'($signed(d));
    endfunction

    function void drop_all();
      foreach (live[i]) begin
        live[i]      = 1'b0;
        slots[i].len = '0;
      end
    endfunction

    function void set_reg(logic [7:0] idx, logic [15:0] val);
      if (idx == REG_MAX_PACKET_LEN) max_len = val;
      else if (idx == REG_FRAME_BYTES) silence_len = val;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void note_item(jb_item_t it);
      res_t              r;
      logic [15:0]       seq;
      logic [15:0]       scan;
      logic [15:0]       gap;
      logic [SLOT_W-1:0] s;
      int                fill;
      r = '0;
      r.status = ST_NONE;
      n_items++;
      case (it.action)
        ACT_STORE: begin
          seq = it.use_seq ? it.seq_in : oldest;
          s   = seq[SLOT_W-1:0];
          if (it.packet_len < MIN_PKT_LEN || it.packet_len > max_len) begin
            r.status = ST_BAD_LEN;
          end else if (!empty && seq_delta(seq, oldest) < 0) begin
            r.status = ST_IGNORED;
          end else begin
            // window overrun: restart the ring at this packet
            if (seq_delta(seq, oldest + 16'(RING_DEPTH)) >= 0) begin
              drop_all();
              oldest = seq;
              newest = seq - 16'd1;
            end
            if (live[s] && slots[s].seq == seq) begin
              r.status = ST_IGNORED;
            end else begin
              slots[s].seq       = seq;
              slots[s].flags     = it.flags;
              slots[s].typ       = it.ptype;
              slots[s].timestamp = it.timestamp;
              slots[s].ssrc      = it.ssrc;
              slots[s].len       = it.payload_len;
              live[s]            = 1'b1;
              if (empty) begin
                oldest = seq;
                newest = seq;
                empty  = 1'b0;
              end
              if (seq_delta(seq, newest) > 0) newest = seq;
              r.status = ST_STORED;
              r.seq    = seq;
              r.slot   = s;
              r.len    = it.payload_len;
            end
          end
        end
        ACT_TAKE: begin
          fill = seq_delta(newest + 16'd1, oldest);
          s    = oldest[SLOT_W-1:0];
          // a hole at the head waits for a resend unless skip_wait is set or the ring is full
          if (!empty && fill > 0 &&
              (it.skip_wait || live[s] || fill >= int'(RING_DEPTH))) begin
            r.seq  = oldest;
            r.slot = s;
            oldest = oldest + 16'd1;
            if (!live[s]) begin
              r.status = ST_SILENCE;
              r.len    = silence_len;
            end else begin
              r.status     = ST_FRAME;
              r.len        = slots[s].len;
              r.flags      = slots[s].flags;
              r.typ        = slots[s].typ;
              r.timestamp  = slots[s].timestamp;
              r.ssrc       = slots[s].ssrc;
              live[s]      = 1'b0;
              slots[s].len = '0;
            end
          end
        end
        ACT_RESEND: begin
          if (seq_delta(oldest, newest) < 0) begin
            scan = oldest;
            while (seq_delta(scan, newest) < 0 && !live[scan[SLOT_W-1:0]])
              scan = scan + 16'd1;
            gap = scan - oldest;
            if (gap != 0) begin
              r.status       = ST_RESEND;
              r.seq          = oldest;
              r.resend_count = (gap > 16'(CNT_MAX)) ? CNT_MAX : gap[CNT_W-1:0];
            end
          end
        end
        default: begin
          drop_all();
          if (it.flush_empty) begin
            empty = 1'b1;
          end else begin
            oldest = it.seq_in;
            newest = it.seq_in - 16'd1;
          end
        end
      endcase
      due_results.push_back(r);
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        if (errors < 10)
          $display("mismatch in result %0d, %s: expected %0h, got %0h",
                   n_checked, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result beat, status %0d seq %0h", got.status, got.seq);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare("status", want.status, got.status);
      compare("out_seq", want.seq, got.seq);
      compare("out_slot", want.slot, got.slot);
      compare("out_len", want.len, got.len);
      compare("out_flags", want.flags, got.flags);
      compare("out_type", want.typ, got.typ);
      compare("out_timestamp", want.timestamp, got.timestamp);
      compare("out_ssrc", want.ssrc, got.ssrc);
      compare("resend_count", want.resend_count, got.resend_count);
      status_hits[int'(want.status)]++;
      n_checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rtpjb_in_if  item_bus ();
  rtpjb_out_if res_bus ();
  rtpjb_cfg_if cfg_bus ();

  rtp_reorder_jitter_buffer_core u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_bus),
    .result_o(res_bus),
    .cfg_i   (cfg_bus)
  );

  ring_scoreboard sb = new();
  logic [15:0]    max_len_now = MAX_LEN_RST;
  logic [15:0]    tx_seq;
  bit             in_calm;
  bit             out_calm;
  int             n_settings = 1;

  always #5 clk = ~clk;

  initial begin
    item_bus.valid         = 1'b0;
    item_bus.action        = ACT_STORE;
    item_bus.seq_in        = '0;
    item_bus.use_seq       = 1'b0;
    item_bus.skip_wait     = 1'b0;
    item_bus.flush_empty   = 1'b0;
    item_bus.packet_len    = '0;
    item_bus.pkt_flags     = '0;
    item_bus.pkt_type      = '0;
    item_bus.pkt_timestamp = '0;
    item_bus.pkt_ssrc      = '0;
    item_bus.payload_len   = '0;
    res_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = '0;
    cfg_bus.data           = '0;
  end

  function automatic logic [15:0] good_len();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return MIN_PKT_LEN;
    if (pick == 1) return max_len_now;
    return 16'($urandom_range(int'(MIN_PKT_LEN), int'(max_len_now)));
  endfunction

  function automatic logic [15:0] bad_len();
    int pick;
    pick = $urandom_range(0, 3);
    if (max_len_now == 16'hffff || pick == 0) return 16'($urandom_range(0, 11));
    if (pick == 1) return max_len_now + 16'd1;
    return 16'($urandom_range(int'(max_len_now) + 1, 65535));
  endfunction

  function automatic jb_item_t base_item(action_e act, logic [15:0] seq);
    jb_item_t it;
    it.action      = act;
    it.seq_in      = seq;
    it.use_seq     = 1'b1;
    it.skip_wait   = 1'b0;
    it.flush_empty = 1'b0;
    it.packet_len  = good_len();
    it.flags       = 8'($urandom);
    it.ptype       = 8'($urandom);
    it.timestamp   = $urandom;
    it.ssrc        = $urandom;
    it.payload_len = 16'($urandom);
    return it;
  endfunction

  // Mostly an in-order stream with light reordering, loss and duplicates.
  function automatic jb_item_t random_item();
    jb_item_t it;
    int       pick;
    int       roll;
    pick = $urandom_range(0, 99);
    it   = base_item(ACT_STORE, tx_seq);
    it.skip_wait   = ($urandom_range(0, 2) == 0);
    it.flush_empty = 1'($urandom);
    if (pick < 46) begin
      roll = $urandom_range(0, 49);
      if (roll == 0) tx_seq = tx_seq + 16'($urandom_range(32, 40000));
      it.seq_in = tx_seq + 16'($urandom_range(0, 6)) - 16'd2;
      if (roll == 1) it.use_seq = 1'b0;
      tx_seq = tx_seq + 16'd1;
    end else if (pick < 76) begin
      it.action = ACT_TAKE;
    end else if (pick < 88) begin
      it.action = ACT_RESEND;
    end else if (pick < 91) begin
      it.action = ACT_FLUSH;
      if (!it.flush_empty) tx_seq = it.seq_in;
    end else if (pick < 96) begin
      it.packet_len = bad_len();
    end else begin
      it.action     = action_e'($urandom_range(0, 3));
      it.seq_in     = 16'($urandom);
      it.use_seq    = 1'($urandom);
      it.packet_len = 16'($urandom);
    end
    return it;
  endfunction

  task automatic drive_item(jb_item_t it);
    int gap;
    if ($urandom_range(0, 59) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_bus.valid         <= 1'b1;
    item_bus.action        <= it.action;
    item_bus.seq_in        <= it.seq_in;
    item_bus.use_seq       <= it.use_seq;
    item_bus.skip_wait     <= it.skip_wait;
    item_bus.flush_empty   <= it.flush_empty;
    item_bus.packet_len    <= it.packet_len;
    item_bus.pkt_flags     <= it.flags;
    item_bus.pkt_type      <= it.ptype;
    item_bus.pkt_timestamp <= it.timestamp;
    item_bus.pkt_ssrc      <= it.ssrc;
    item_bus.payload_len   <= it.payload_len;
    do @(posedge clk); while (item_bus.ready !== 1'b1);
    sb.note_item(it);
  endtask

  // Drop valid and wait until every expected beat is back.
  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    sb.set_reg(idx, val);
    if (idx == REG_MAX_PACKET_LEN) max_len_now = val;
  endtask

  task automatic run_phase(logic [15:0] max_len, logic [15:0] frame_len, int n,
                           logic [15:0] start);
    write_reg(REG_MAX_PACKET_LEN, max_len);
    write_reg(REG_FRAME_BYTES, frame_len);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    n_settings++;
    tx_seq = start;
    repeat (n) drive_item(random_item());
    settle();
  endtask

  task automatic run_directed();
    jb_item_t it;
    drive_item(base_item(ACT_TAKE, 16'h0000));      // empty ring
    drive_item(base_item(ACT_RESEND, 16'h0000));
    it = base_item(ACT_STORE, 16'h0005);
    it.packet_len = MIN_PKT_LEN - 16'd1;
    drive_item(it);
    it.packet_len = MAX_LEN_RST + 16'd1;
    drive_item(it);
    it = base_item(ACT_STORE, 16'hfffe);
    it.packet_len  = MIN_PKT_LEN;
    it.flags       = '0;
    it.ptype       = '0;
    it.timestamp   = '0;
    it.ssrc        = '0;
    it.payload_len = '0;
    drive_item(it);
    drive_item(it);                                 // duplicate
    it = base_item(ACT_STORE, 16'h0001);           // across the wrap
    it.packet_len  = MAX_LEN_RST;
    it.flags       = '1;
    it.ptype       = '1;
    it.timestamp   = '1;
    it.ssrc        = '1;
    it.payload_len = '1;
    drive_item(it);
    drive_item(base_item(ACT_STORE, 16'hfffd));     // late
    drive_item(base_item(ACT_TAKE, 16'h0000));
    drive_item(base_item(ACT_RESEND, 16'h0000));
    drive_item(base_item(ACT_TAKE, 16'h0000));      // hole, wait for resend
    it = base_item(ACT_TAKE, 16'h0000);
    it.skip_wait = 1'b1;
    drive_item(it);
    it = base_item(ACT_STORE, 16'h7777);
    it.use_seq = 1'b0;                              // store at the head
    drive_item(it);
    drive_item(base_item(ACT_TAKE, 16'h0000));
    drive_item(base_item(ACT_TAKE, 16'h0000));
    drive_item(base_item(ACT_TAKE, 16'h0000));      // drained
    it = base_item(ACT_FLUSH, 16'h8000);
    drive_item(it);
    drive_item(base_item(ACT_STORE, 16'h801f));     // ring now full
    drive_item(base_item(ACT_TAKE, 16'h0000));      // full ring gives silence
    drive_item(base_item(ACT_RESEND, 16'h0000));
    drive_item(base_item(ACT_STORE, 16'h9000));     // window overrun
    it = base_item(ACT_FLUSH, 16'h0000);
    it.flush_empty = 1'b1;
    drive_item(it);
    drive_item(base_item(ACT_TAKE, 16'h0000));
    drive_item(base_item(ACT_STORE, 16'h0000));
    drive_item(base_item(ACT_FLUSH, 16'hffff));
    settle();
  endtask

  initial begin : result_sink
    res_t got;
    int   stall;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 17);
      @(negedge clk);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (res_bus.valid !== 1'b1);
      got.status       = status_e'(res_bus.status);
      got.seq          = res_bus.out_seq;
      got.slot         = res_bus.out_slot;
      got.len          = res_bus.out_len;
      got.flags        = res_bus.out_flags;
      got.typ          = res_bus.out_type;
      got.timestamp    = res_bus.out_timestamp;
      got.ssrc         = res_bus.out_ssrc;
      got.resend_count = res_bus.resend_count;
      sb.check_result(got);
    end
  end

  initial begin : watchdog
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    tx_seq = 16'($urandom);
    repeat (400) drive_item(random_item());
    settle();
    run_phase(MIN_PKT_LEN, 16'h0000, 300, 16'($urandom));
    run_phase(16'hffff, 16'hffff, 400, 16'hffe0);
    run_phase(16'($urandom_range(12, 65535)), 16'($urandom), 400, 16'($urandom));
    run_phase(16'($urandom_range(12, 200)), 16'($urandom), 500, 16'($urandom));
    if (sb.pending() != 0) begin
      $display("%0d expected results never arrived", sb.pending());
      sb.errors += sb.pending();
    end
    $display("%0d items over %0d register settings, %0d results checked, %0d errors",
             sb.n_items, n_settings, sb.n_checked, sb.errors);
    $display("stored %0d, bad length %0d, ignored %0d, frames %0d, silence %0d, resend %0d",
             sb.status_hits[ST_STORED], sb.status_hits[ST_BAD_LEN],
             sb.status_hits[ST_IGNORED], sb.status_hits[ST_FRAME],
             sb.status_hits[ST_SILENCE], sb.status_hits[ST_RESEND]);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
